// ===== sv/mfu_pkg.sv =====
// Shared types and constants for the MAC / LIF / fusion execution unit.
// No dependencies; all other files but the two channel interfaces import this package.
package mfu_pkg;

   localparam logic [1:0] FUNC_MAC  = 2'd0;
   localparam logic [1:0] FUNC_LIF  = 2'd1;
   localparam logic [1:0] FUNC_FUSE = 2'd2;

   // Leak factor 95/100 and fusion weight range 127.
   localparam logic signed [15:0] LEAK_NUM  = 16'sd95;
   localparam logic signed [8:0]  FUSE_DEN  = 9'sd127;
   localparam logic signed [31:0] SPIKE_VAL = 32'sd127;
   localparam logic signed [10:0] BYTE_MAX  = 11'sd127;
   localparam logic signed [10:0] BYTE_MIN  = -11'sd128;

   // Reciprocals for truncating division of magnitudes: floor(x*R >> S).
   // Exact for magnitudes up to 24320 (leak) and 49024 (fusion).
   localparam logic [12:0] LEAK_RECIP = 13'd5243;
   localparam logic [16:0] FUSE_RECIP = 17'd66053;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [7:0]  op_a;
      logic signed [7:0]  op_b;
      logic signed [7:0]  op_c;
      logic signed [31:0] accumulator;
   } op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] accumulator;
      logic signed [15:0] prod;
      logic               spike;
      logic signed [15:0] leak;
      logic signed [16:0] fuse;
   } mid_type;

endpackage

// ===== sv/mfu_req_if.sv =====
// Operation channel: valid/ready handshake with the operand payload.
// Uses no package.
interface mfu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [7:0]  op_a;
   logic signed [7:0]  op_b;
   logic signed [7:0]  op_c;
   logic signed [31:0] accumulator;

   modport source(output valid, func, op_a, op_b, op_c, accumulator, input ready);
   modport sink(input valid, func, op_a, op_b, op_c, accumulator, output ready);
endinterface

// ===== sv/mfu_rsp_if.sv =====
// Result channel: valid/ready handshake with one signed 32-bit result.
// Uses no package.
interface mfu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;

   modport source(output valid, result, input ready);
   modport sink(input valid, result, output ready);
endinterface

// ===== sv/mfu_prod.sv =====
// First stage logic: the byte products, the membrane sum, the leak product and the spike compare.
// Depends on mfu_pkg.
module mfu_prod
   import mfu_pkg::*;
(
   input  op_type  op,
   output mid_type mid
);

   logic signed [8:0] pot;
   logic signed [8:0] wgt;

   always_comb begin
      pot = 9'(op.op_a) + 9'(op.op_b);
      // The complementary weight ranges 0..255 for a signed weight.
      wgt = FUSE_DEN - 9'(op.op_c);

      mid.func        = op.func;
      mid.accumulator = op.accumulator;
      mid.prod        = 16'(op.op_a) * 16'(op.op_b);
      mid.spike       = (pot >= 9'(op.op_c));
      mid.leak        = 16'(pot) * LEAK_NUM;
      mid.fuse        = 17'(op.op_a) * 17'(op.op_c) + 17'(op.op_b) * 17'(wgt);
   end

endmodule

// ===== sv/mfu_scale.sv =====
// Second stage logic: accumulate, truncating divisions by 100 and 127,
// clipping to a signed byte and result selection. Depends on mfu_pkg.
module mfu_scale
   import mfu_pkg::*;
(
   input  mid_type            mid,
   output logic signed [31:0] result
);

   logic              leak_neg;
   logic [14:0]       leak_mag;
   logic [27:0]       leak_prod;
   logic signed [10:0] leak_div;
   logic              fuse_neg;
   logic [15:0]       fuse_mag;
   logic [32:0]       fuse_prod;
   logic signed [10:0] fuse_div;

   function automatic logic signed [7:0] clip8(input logic signed [10:0] x);
      logic signed [10:0] y;
      y = x;
      if (x > BYTE_MAX) y = BYTE_MAX;
      if (x < BYTE_MIN) y = BYTE_MIN;
      return 8'(y);
   endfunction

   always_comb begin
      // Divide the magnitude and restore the sign, which truncates toward zero.
      leak_neg  = mid.leak[15];
      leak_mag  = 15'(leak_neg ? -mid.leak : mid.leak);
      leak_prod = 28'(leak_mag) * 28'(LEAK_RECIP);
      leak_div  = 11'(leak_prod[27:19]);
      if (leak_neg) leak_div = -leak_div;

      fuse_neg  = mid.fuse[16];
      fuse_mag  = 16'(fuse_neg ? -mid.fuse : mid.fuse);
      fuse_prod = 33'(fuse_mag) * 33'(FUSE_RECIP);
      fuse_div  = 11'(fuse_prod[32:23]);
      if (fuse_neg) fuse_div = -fuse_div;

      case (mid.func)
         FUNC_MAC: begin
            result = mid.accumulator + 32'(mid.prod);
         end
         FUNC_LIF: begin
            result = mid.spike ? SPIKE_VAL : 32'(clip8(leak_div));
         end
         FUNC_FUSE: begin
            result = 32'(clip8(fuse_div));
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== sv/custom_mac_lif_fusion_unit_top.sv =====
// Execution unit for multiply-accumulate, leaky integrate-and-fire and
// attention fusion operations.
//
// req_chan carries one operation per beat (func, op_a, op_b, op_c,
// accumulator); rsp_chan returns one signed 32-bit result per beat, in
// order. A beat moves at a rising edge with valid and ready both high.
//
// The block is a three-register pipeline: operand register, product
// register after the byte multipliers, and result register after the
// reciprocal dividers and the clip. An accepted operation passes through the
// product register and then the result register before its result is offered,
// and one operation is taken every cycle while rsp_chan.ready stays high.
//
// When the receiver holds rsp_chan.ready low, the stages fill up behind the
// waiting result; req_chan.ready drops only once every stage is occupied,
// and no beat is lost. Reset, synchronous and active high, empties the
// pipeline; there is no other state.
//
// Depends on mfu_pkg, mfu_req_if, mfu_rsp_if, mfu_prod and mfu_scale.
module custom_mac_lif_fusion_unit_top
   import mfu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mfu_req_if.sink    req_chan,
   mfu_rsp_if.source  rsp_chan
);

   op_type             op_ff, op_in;
   logic               op_valid_ff, op_valid_in;
   mid_type            mid_ff, mid_in;
   mid_type            mid_comb;
   logic               mid_valid_ff, mid_valid_in;
   logic signed [31:0] result_ff, result_in;
   logic signed [31:0] result_comb;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free, mid_free, op_free;

   mfu_prod u_prod (
      .op  (op_ff),
      .mid (mid_comb)
   );

   mfu_scale u_scale (
      .mid    (mid_ff),
      .result (result_comb)
   );

   // A stage may load when it is empty or when its content moves on.
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign mid_free = !mid_valid_ff || rsp_free;
   assign op_free  = !op_valid_ff || mid_free;

   assign req_chan.ready  = op_free;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = result_ff;

   always_comb begin
      op_in        = op_ff;
      op_valid_in  = op_valid_ff;
      mid_in       = mid_ff;
      mid_valid_in = mid_valid_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;

      if (op_free) begin
         op_valid_in       = req_chan.valid;
         op_in.func        = req_chan.func;
         op_in.op_a        = req_chan.op_a;
         op_in.op_b        = req_chan.op_b;
         op_in.op_c        = req_chan.op_c;
         op_in.accumulator = req_chan.accumulator;
      end
      if (mid_free) begin
         mid_valid_in = op_valid_ff;
         mid_in       = mid_comb;
      end
      if (rsp_free) begin
         rsp_valid_in = mid_valid_ff;
         result_in    = result_comb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      mid_ff    <= mid_in;
      result_ff <= result_in;
   end

endmodule

// ===== tb/mfu_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the MAC / LIF / fusion unit: predicts each result from the accepted
// operation and compares it with the result beats in order. Depends on mfu_pkg,
// mfu_req_if and mfu_rsp_if.
module mfu_result_checker
   import mfu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mfu_req_if   req_mon,
   mfu_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending,
   output int   results_checked
);

   localparam int LEAK_MUL    = 95;
   localparam int LEAK_DIV    = 100;
   localparam int FUSE_SCALE  = 127;
   localparam int SPIKE_OUT   = 127;
   localparam int BYTE_HI     = 127;
   localparam int BYTE_LO     = -128;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      op_type             op;
      logic signed [31:0] value;
   } expected_beat_type;

   expected_beat_type expected_results[$];
   expected_beat_type want;
   op_type            seen_op;

   function automatic int clip_byte(int x);
      if (x > BYTE_HI) return BYTE_HI;
      if (x < BYTE_LO) return BYTE_LO;
      return x;
   endfunction

   // Division on int truncates toward zero, as the unit does.
   function automatic logic signed [31:0] unit_result(op_type op);
      int a, b, c, pot, num;
      a = op.op_a;
      b = op.op_b;
      c = op.op_c;
      case (op.func)
         FUNC_MAC: return op.accumulator + a * b;
         FUNC_LIF: begin
            pot = a + b;
            if (pot >= c) return SPIKE_OUT;
            return clip_byte(pot * LEAK_MUL / LEAK_DIV);
         end
         FUNC_FUSE: begin
            num = a * c + b * (FUSE_SCALE - c);
            return clip_byte(num / FUSE_SCALE);
         end
         default: return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pending <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            seen_op.func        = req_mon.func;
            seen_op.op_a        = req_mon.op_a;
            seen_op.op_b        = req_mon.op_b;
            seen_op.op_c        = req_mon.op_c;
            seen_op.accumulator = req_mon.accumulator;
            expected_results.push_back('{seen_op, unit_result(seen_op)});
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: result beat %0d with no operation outstanding",
                           $time, rsp_mon.result);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.result !== want.value) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: func %0d a %0d b %0d c %0d acc %0d: expected %0d, got %0d",
                              $time, want.op.func, want.op.op_a, want.op.op_b, want.op.op_c,
                              want.op.accumulator, want.value, rsp_mon.result);
               end
            end
         end
         pending <= expected_results.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, operation and result traffic with random gaps,
// and the verdict. Depends on mfu_pkg, the channel interfaces, the unit and mfu_result_checker.
module tb_top;
   import mfu_pkg::*;

   localparam logic [1:0] FUNC_UNDEF = 2'd3;
   localparam int RANDOM_OPS   = 1830;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_LIMIT   = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_req = 1'b0;
   int   sent_by_func[4];
   int   errors, pending, checked;

   mfu_req_if req_chan();
   mfu_rsp_if rsp_chan();

   custom_mac_lif_fusion_unit_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mfu_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .error_count     (errors),
      .pending         (pending),
      .results_checked (checked)
   );

   always #5 clock = ~clock;

   // Mostly no gap or a short one, now and then a long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic logic signed [7:0] random_byte();
      case ($urandom_range(9))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return 8'sd0;
         3: return -8'sd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic signed [31:0] random_acc();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF - 32'($urandom_range(20000));
         1: return 32'h8000_0000 + 32'($urandom_range(20000));
         default: return 32'($urandom);
      endcase
   endfunction

   // Holds valid high across back-to-back beats; lowers it only for a real gap.
   task automatic send_op(logic [1:0] func, logic signed [7:0] a, logic signed [7:0] b,
                          logic signed [7:0] c, logic signed [31:0] acc, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= func;
      req_chan.op_a        <= a;
      req_chan.op_b        <= b;
      req_chan.op_c        <= c;
      req_chan.accumulator <= acc;
      do @(posedge clock); while (!req_chan.ready);
      sent_by_func[func]++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : receiver
      int run, gap;
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_req) begin
            hold_req       <= 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            run = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
            rsp_chan.ready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = random_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]         func;
      logic signed [7:0]  a, b, c;
      int                 sel, near;
      bit                 burst;
      req_chan.valid       = 1'b0;
      req_chan.func        = FUNC_MAC;
      req_chan.op_a        = '0;
      req_chan.op_b        = '0;
      req_chan.op_c        = '0;
      req_chan.accumulator = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, accumulator wrap both ways, spike threshold,
      // leak clipping and truncation, weights at the ends and below zero, undefined functions.
      send_op(FUNC_MAC, -8'sd128, -8'sd128, 8'sd55, 32'h7FFF_FFFF, random_gap());
      send_op(FUNC_MAC, 8'sd127, -8'sd128, -8'sd9, 32'h8000_0000, random_gap());
      send_op(FUNC_MAC, 8'sd127, 8'sd127, 8'sd0, 32'h0000_0000, random_gap());
      send_op(FUNC_MAC, 8'sd0, -8'sd77, 8'sd127, 32'hDEAD_BEEF, random_gap());
      send_op(FUNC_MAC, -8'sd1, 8'sd1, -8'sd1, 32'hFFFF_FFFF, random_gap());
      send_op(FUNC_LIF, 8'sd127, 8'sd127, 8'sd127, 32'h1234_5678, random_gap());
      send_op(FUNC_LIF, 8'sd60, 8'sd67, 8'sd127, 32'h0, random_gap());
      send_op(FUNC_LIF, 8'sd60, 8'sd66, 8'sd127, 32'hFFFF_0000, random_gap());
      send_op(FUNC_LIF, -8'sd128, -8'sd128, 8'sd127, 32'h0, random_gap());
      send_op(FUNC_LIF, -8'sd128, -8'sd128, -8'sd128, 32'h0, random_gap());
      send_op(FUNC_LIF, -8'sd1, 8'sd0, 8'sd5, 32'h0, random_gap());
      send_op(FUNC_LIF, 8'sd1, 8'sd0, 8'sd2, 32'h0, random_gap());
      send_op(FUNC_LIF, -8'sd100, -8'sd35, -8'sd128, 32'h0, random_gap());
      send_op(FUNC_FUSE, 8'sd127, -8'sd128, -8'sd128, 32'h0, random_gap());
      send_op(FUNC_FUSE, -8'sd128, 8'sd127, -8'sd128, 32'h0, random_gap());
      send_op(FUNC_FUSE, 8'sd55, -8'sd33, 8'sd127, 32'h0, random_gap());
      send_op(FUNC_FUSE, 8'sd55, -8'sd33, 8'sd0, 32'hAAAA_5555, random_gap());
      send_op(FUNC_FUSE, 8'sd1, 8'sd0, 8'sd1, 32'h0, random_gap());
      send_op(FUNC_FUSE, -8'sd1, 8'sd0, 8'sd1, 32'h0, random_gap());
      send_op(FUNC_FUSE, -8'sd128, -8'sd128, 8'sd64, 32'h0, random_gap());
      send_op(FUNC_UNDEF, 8'sd127, -8'sd128, 8'sd127, 32'h7FFF_FFFF, random_gap());
      send_op(FUNC_UNDEF, -8'sd1, -8'sd1, -8'sd1, 32'hFFFF_FFFF, random_gap());
      drain_results();

      for (int i = 0; i < RANDOM_OPS; i++) begin
         // Back up the pipeline while the result side holds off.
         if (i == 600) hold_req <= 1'b1;
         if (i == 1200) drain_results();
         burst = (i >= 600 && i < 640) || (i % 250 < 30);
         sel = $urandom_range(19);
         if (sel < 6) func = FUNC_MAC;
         else if (sel < 12) func = FUNC_LIF;
         else if (sel < 19) func = FUNC_FUSE;
         else func = FUNC_UNDEF;
         a = random_byte();
         b = random_byte();
         c = random_byte();
         // Put the threshold right at the membrane sum now and then.
         if (func == FUNC_LIF && $urandom_range(9) < 4) begin
            near = int'(a) + int'(b) + $urandom_range(4) - 2;
            c = (near > 127) ? 8'sd127 : (near < -128) ? -8'sd128 : 8'(near);
         end
         send_op(func, a, b, c, random_acc(), burst ? 0 : random_gap());
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d MAC, %0d LIF, %0d fusion and %0d undefined operations;",
               sent_by_func[FUNC_MAC], sent_by_func[FUNC_LIF], sent_by_func[FUNC_FUSE],
               sent_by_func[FUNC_UNDEF]);
      $display("%0d results compared, %0d mismatches, %0d still outstanding.",
               checked, errors, pending);
      if (errors == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
